### hw/rtl/lgge_pkg.sv
`timescale 1ns / 1ps
package lgge_pkg;

  localparam int CFG_W = 7;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ADVANCE,
    CMD_REPORT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               set_alive;
    logic               index_error;
  } cmd_t;

  // zero acts as one, values above the limit act as the limit
  function automatic logic [CFG_W-1:0] lgge_eff(logic [CFG_W-1:0] value, int limit);
    if (value == '0) begin
      return CFG_W'(1);
    end
    if (int'(value) > limit) begin
      return CFG_W'(limit);
    end
    return value;
  endfunction

endpackage

### hw/rtl/lgge_ram.sv
`timescale 1ns / 1ps
module lgge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lgge_front.sv
`timescale 1ns / 1ps
module lgge_front import lgge_pkg::*; (
  input  logic             tvalid_i,
  input  logic [15:0]      tdata_i,
  output logic             tready_o,
  input  logic [CFG_W-1:0] nr_i,
  input  logic [CFG_W-1:0] nc_i,
  input  logic             q_full_i,
  input  logic             init_done_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [1:0]       func;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             out_of_grid;

  assign func = tdata_i[1:0];
  assign row  = tdata_i[7:2];
  assign col  = tdata_i[13:8];

  assign out_of_grid = ({1'b0, row} >= nr_i) || ({1'b0, col} >= nc_i);

  assign tready_o = init_done_i && !q_full_i;
  assign push_o   = tvalid_i && tready_o;

  always_comb begin
    cmd_o.row         = row;
    cmd_o.col         = col;
    cmd_o.set_alive   = tdata_i[14];
    cmd_o.index_error = 1'b0;
    cmd_o.kind        = CMD_REPORT;
    case (func)
      FUNC_WRITE: begin
        cmd_o.kind        = out_of_grid ? CMD_REPORT : CMD_WRITE;
        cmd_o.index_error = out_of_grid;
      end
      FUNC_READ: begin
        cmd_o.kind        = out_of_grid ? CMD_REPORT : CMD_READ;
        cmd_o.index_error = out_of_grid;
      end
      FUNC_ADVANCE: cmd_o.kind = CMD_ADVANCE;
      default: cmd_o.kind = CMD_REPORT;
    endcase
  end

endmodule

### hw/rtl/lgge_queue.sv
`timescale 1ns / 1ps
module lgge_queue import lgge_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output cmd_t cmd_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == NW'(QUEUE_DEPTH);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

### hw/rtl/lgge_back.sv
`timescale 1ns / 1ps
module lgge_back import lgge_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] nr_i,
  input  logic [CFG_W-1:0] nc_i,
  input  logic             q_valid_i,
  input  cmd_t             cmd_i,
  output logic             q_pop_o,
  output logic             init_done_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int TW = CFG_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_GEN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [RW-1:0]       clr_q;
  logic [TW-1:0]       t_q;
  logic [TW-1:0]       nr_ext;
  logic [MAX_COLS-1:0] up_q, mid_q;
  cmd_t                cmd_q;
  logic                res_alive_q, res_err_q;
  logic                out_valid_q;
  logic [1:0]          out_data_q;

  logic                ram_we, ram_re;
  logic [RW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]       col_idx;
  logic                lo_valid;
  logic [MAX_COLS-1:0] lo_row, col_mask, up_m, mid_m, lo_m, new_row;
  logic [MAX_COLS+1:0] up_p, mid_p, lo_p;
  logic [3:0]          nb_cnt [MAX_COLS];

  lgge_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign nr_ext   = TW'(nr_i);
  assign col_idx  = CW'(cmd_q.col);
  assign lo_valid = (t_q != '0) && ((t_q - TW'(1)) < nr_ext);
  assign lo_row   = lo_valid ? ram_rdata : '0;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = c < int'(nc_i);
    end
  end

  assign up_m  = up_q & col_mask;
  assign mid_m = mid_q & col_mask;
  assign lo_m  = lo_row & col_mask;
  assign up_p  = {1'b0, up_m, 1'b0};
  assign mid_p = {1'b0, mid_m, 1'b0};
  assign lo_p  = {1'b0, lo_m, 1'b0};

  // one lane per column: eight neighbors, b3/s23
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      nb_cnt[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                + 4'(mid_p[c]) + 4'(mid_p[c+2])
                + 4'(lo_p[c]) + 4'(lo_p[c+1]) + 4'(lo_p[c+2]);
      new_row[c] = (nb_cnt[c] == BIRTH_COUNT) || (mid_m[c] && nb_cnt[c] == STAY_COUNT);
    end
  end

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign init_done_o = state_q != ST_CLEAR;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = RW'(cmd_i.row);
    ram_we    = 1'b0;
    ram_waddr = RW'(cmd_q.row);
    ram_wdata = ram_rdata;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_re = q_valid_i && (cmd_i.kind == CMD_WRITE || cmd_i.kind == CMD_READ);
      end
      ST_CELL_WR: begin
        ram_we             = 1'b1;
        ram_wdata[col_idx] = cmd_q.set_alive;
      end
      ST_GEN: begin
        ram_re    = t_q < nr_ext;
        ram_raddr = RW'(t_q);
        ram_we    = t_q >= TW'(2);
        ram_waddr = RW'(t_q - TW'(2));
        ram_wdata = (new_row & col_mask) | (mid_q & ~col_mask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      t_q         <= '0;
      up_q        <= '0;
      mid_q       <= '0;
      cmd_q       <= '0;
      res_alive_q <= 1'b0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(MAX_ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            cmd_q       <= cmd_i;
            res_alive_q <= 1'b0;
            res_err_q   <= cmd_i.index_error;
            case (cmd_i.kind)
              CMD_WRITE: state_q <= ST_CELL_WR;
              CMD_READ:  state_q <= ST_CELL_RD;
              CMD_ADVANCE: begin
                t_q     <= '0;
                up_q    <= '0;
                mid_q   <= '0;
                state_q <= ST_GEN;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_CELL_RD: begin
          res_alive_q <= ram_rdata[col_idx];
          state_q     <= ST_DONE;
        end
        ST_CELL_WR: state_q <= ST_DONE;
        ST_GEN: begin
          t_q   <= t_q + TW'(1);
          up_q  <= mid_q;
          mid_q <= lo_row;
          if (t_q == nr_ext + TW'(1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q <= {res_err_q, res_alive_q};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

  ap_gen_write_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && ram_we) |-> (int'(ram_waddr) < int'(nr_i)))
    else $error("generation writes a row outside the grid");

  ap_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside the done state");

  ap_cell_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL_WR) |-> $past(state_q == ST_IDLE && ram_re))
    else $error("cell write without a preceding row read");

endmodule

### hw/rtl/life_grid_generation_engine_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake                 | payload
// s_axis    | in  | s_axis_tvalid/tready      | tdata: func, row, col, set_alive
// m_axis    | out | m_axis_tvalid/tready      | tdata: cell_alive, index_error
// apb       | in  | psel/penable/pwrite/pready| 0x0 rows_in_use, 0x4 cols_in_use
//
// cell write reads the row, then writes it back with the cell changed; cell read reads the row, takes the cell
// an out-of-grid access or unused func goes straight to the result without a grid ram access
// advance streams one row per cycle through the grid ram
// after reset a clearing pass writes MAX_ROWS rows, s_axis_tready stays low meanwhile
// a 2-entry request queue and the output register let either side stall
module life_grid_generation_engine_core import lgge_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // func[1:0], row[7:2], col[13:8], set_alive[14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // cell_alive[0], index_error[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] rows_q, cols_q;
  logic [CFG_W-1:0] nr, nc;
  logic             push, q_full, q_valid, q_pop, init_done;
  cmd_t             push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = {25'b0, paddr[2] ? cols_q : rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(64);
      cols_q <= CFG_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        cols_q <= pwdata[CFG_W-1:0];
      end else begin
        rows_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign nr = lgge_eff(rows_q, MAX_ROWS);
  assign nc = lgge_eff(cols_q, MAX_COLS);

  lgge_front u_front (
    .tvalid_i   (s_axis_tvalid),
    .tdata_i    (s_axis_tdata),
    .tready_o   (s_axis_tready),
    .nr_i       (nr),
    .nc_i       (nc),
    .q_full_i   (q_full),
    .init_done_i(init_done),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lgge_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .cmd_o  (head_cmd)
  );

  lgge_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nr_i         (nr),
    .nc_i         (nc),
    .q_valid_i    (q_valid),
    .cmd_i        (head_cmd),
    .q_pop_o      (q_pop),
    .init_done_o  (init_done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

### tb/sv/tb_life_grid_generation_engine_core.sv
`timescale 1ns / 1ps
module tb_life_grid_generation_engine_core import lgge_pkg::*;;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int NUM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [2:0] REG_ROWS_IN_USE = 3'h0;
  localparam logic [2:0] REG_COLS_IN_USE = 3'h4;

  typedef struct packed {
    logic index_error;
    logic cell_alive;
  } life_result_t;

  class life_scoreboard;
    bit [6:0] rows_reg;
    bit [6:0] cols_reg;
    bit [GRID_COLS-1:0] cells [GRID_ROWS];
    life_result_t pending_results [$];
    int n_writes, n_reads, n_live_reads, n_advances, n_index_errors, n_checked, n_errors;

    function new();
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int span(bit [6:0] value, int limit);
      if (value == 0) return 1;
      if (int'(value) > limit) return limit;
      return int'(value);
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] value);
      if (addr == REG_ROWS_IN_USE) rows_reg = value[6:0];
      else if (addr == REG_COLS_IN_USE) cols_reg = value[6:0];
    endfunction

    function void note_request(logic [15:0] data);
      logic [1:0] func;
      int r, c, nr, nc, rr, cc, dr, dc, n;
      bit [GRID_COLS-1:0] next_cells [GRID_ROWS];
      life_result_t res;
      func = data[1:0];
      r = int'(data[7:2]);
      c = int'(data[13:8]);
      nr = span(rows_reg, GRID_ROWS);
      nc = span(cols_reg, GRID_COLS);
      res = '0;
      case (func)
        FUNC_WRITE, FUNC_READ: begin
          if (r >= nr || c >= nc) begin
            res.index_error = 1'b1;
            n_index_errors++;
          end else if (func == FUNC_WRITE) begin
            cells[r][c] = data[14];
            n_writes++;
          end else begin
            res.cell_alive = cells[r][c];
            n_reads++;
            if (cells[r][c]) n_live_reads++;
          end
        end
        FUNC_ADVANCE: begin
          next_cells = cells;
          for (rr = 0; rr < nr; rr++) begin
            for (cc = 0; cc < nc; cc++) begin
              n = 0;
              for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                  if ((dr != 0 || dc != 0) && rr + dr >= 0 && rr + dr < nr &&
                      cc + dc >= 0 && cc + dc < nc) begin
                    n += int'(cells[rr+dr][cc+dc]);
                  end
                end
              end
              next_cells[rr][cc] = (n == int'(BIRTH_COUNT)) ||
                                   (cells[rr][cc] && n == int'(STAY_COUNT));
            end
          end
          cells = next_cells;
          n_advances++;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] data);
      life_result_t want;
      n_checked++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: expected no result, actual tdata %b", $time, data);
        return;
      end
      want = pending_results.pop_front();
      if (data[0] !== want.cell_alive) begin
        n_errors++;
        $display("%0t: cell_alive expected %0b actual %0b", $time, want.cell_alive, data[0]);
      end
      if (data[1] !== want.index_error) begin
        n_errors++;
        $display("%0t: index_error expected %0b actual %0b", $time, want.index_error,
                 data[1]);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // func[1:0], row[7:2], col[13:8], set_alive[14]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // cell_alive[0], index_error[1]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  life_scoreboard sb;
  bit full_speed;
  int idle_cycles = 0;
  int rows_plan [NUM_PHASES] = '{64, 1, 0, 127, 3, 64, 1, 9, 65, 100, 0};
  int cols_plan [NUM_PHASES] = '{64, 1, 0, 127, 5, 1, 64, 7, 100, 2, 0};

  life_grid_generation_engine_core i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // most accesses land in an 8x8 window so that patterns grow dense enough to evolve
  function automatic int pick_index(int n, int focus);
    if (n > 8 && $urandom_range(9) < 7) return focus + $urandom_range(7);
    return $urandom_range(n - 1);
  endfunction

  task automatic send_request(input logic [1:0] func, input int row, input int col,
                              input bit alive);
    int gap;
    gap = full_speed ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, alive, 6'(col), 6'(row), func};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(s_axis_tdata);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [6:0] value);
    logic [31:0] word;
    word = {25'($urandom), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(addr, word);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    int hold, stall;
    forever begin
      m_axis_tready <= 1'b1;
      hold = ($urandom_range(9) == 0) ? 60 : $urandom_range(1, 6);
      repeat (hold) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase, i, k, nr, nc, focus_r, focus_c, rows_val, cols_val;
    sb = new();
    full_speed = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk_i);
      end
      rows_val = (phase == NUM_PHASES - 1) ? $urandom_range(127) : rows_plan[phase];
      cols_val = (phase == NUM_PHASES - 1) ? $urandom_range(127) : cols_plan[phase];
      write_register(REG_ROWS_IN_USE, 7'(rows_val));
      write_register(REG_COLS_IN_USE, 7'(cols_val));
      nr = sb.span(sb.rows_reg, GRID_ROWS);
      nc = sb.span(sb.cols_reg, GRID_COLS);
      focus_r = (nr > 8) ? $urandom_range(nr - 8) : 0;
      focus_c = (nc > 8) ? $urandom_range(nc - 8) : 0;

      if (phase == 0) begin
        // corners, dead reads, clearing a cell, unused func
        send_request(FUNC_WRITE, 0, 0, 1'b1);
        send_request(FUNC_WRITE, 63, 63, 1'b1);
        send_request(FUNC_READ, 0, 0, 1'b0);
        send_request(FUNC_READ, 63, 63, 1'b0);
        send_request(FUNC_READ, 0, 63, 1'b0);
        send_request(FUNC_WRITE, 63, 63, 1'b0);
        send_request(FUNC_READ, 63, 63, 1'b1);
        send_request(FUNC_NOP, 63, 63, 1'b1);
        // blinker flips from horizontal to vertical and back
        send_request(FUNC_WRITE, 10, 10, 1'b1);
        send_request(FUNC_WRITE, 10, 11, 1'b1);
        send_request(FUNC_WRITE, 10, 12, 1'b1);
        send_request(FUNC_ADVANCE, 63, 63, 1'b1);
        send_request(FUNC_READ, 9, 11, 1'b0);
        send_request(FUNC_READ, 10, 11, 1'b0);
        send_request(FUNC_READ, 11, 11, 1'b0);
        send_request(FUNC_READ, 10, 10, 1'b0);
        send_request(FUNC_ADVANCE, 0, 0, 1'b0);
        send_request(FUNC_READ, 10, 10, 1'b0);
        // birth and survival against the grid edge
        send_request(FUNC_WRITE, 0, 0, 1'b1);
        send_request(FUNC_WRITE, 0, 1, 1'b1);
        send_request(FUNC_WRITE, 1, 0, 1'b1);
        send_request(FUNC_ADVANCE, 0, 0, 1'b0);
        send_request(FUNC_READ, 1, 1, 1'b0);
      end

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 0 && i == 85) drain();
        full_speed = ((i / 40) % 5) == 4;
        k = $urandom_range(99);
        if (k < 6) begin
          send_request(FUNC_NOP, $urandom_range(63), $urandom_range(63),
                       1'($urandom_range(1)));
        end else if (k < 14) begin
          send_request($urandom_range(1) ? FUNC_WRITE : FUNC_READ, $urandom_range(63),
                       $urandom_range(63), 1'($urandom_range(1)));
        end else if (k < 26) begin
          send_request(FUNC_ADVANCE, $urandom_range(63), $urandom_range(63),
                       1'($urandom_range(1)));
        end else if (k < 64) begin
          send_request(FUNC_WRITE, pick_index(nr, focus_r), pick_index(nc, focus_c),
                       $urandom_range(99) < 45);
        end else begin
          send_request(FUNC_READ, pick_index(nr, focus_r), pick_index(nc, focus_c),
                       1'($urandom_range(1)));
        end
      end
    end

    full_speed = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.n_errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
    end
    $display("run covered %0d cell writes, %0d reads (%0d live), %0d generations",
             sb.n_writes, sb.n_reads, sb.n_live_reads, sb.n_advances);
    $display("and %0d out-of-grid accesses over %0d grid sizes, %0d results compared",
             sb.n_index_errors, NUM_PHASES, sb.n_checked);
    if (sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
